// ===== hw/rtl/cbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN bit-timing calculator package
// Field widths, reset values, limits, register indexes and the sequencer
// states shared by the calculator modules.
// ----------------------------------------------------------------------------
package cbtc_pkg;

	localparam int CLK_W   = 28;
	localparam int RATE_W  = 28;
	localparam int PROP_W  = 4;
	localparam int FIELD_W = 8;
	localparam int NBT_W   = 5;
	localparam int DIV_W   = 28;
	localparam int APB_W   = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CLK_W-1:0]   CLOCK_RESET  = 28'd80_000_000;
	localparam logic [PROP_W-1:0]  PROP_RESET   = 4'd5;
	localparam logic [DIV_W-1:0]   QUANTA_LIMIT = 28'd17;
	localparam logic [FIELD_W-1:0] PRE_FIRST    = 8'd1;
	localparam logic [FIELD_W-1:0] PRE_LAST     = 8'd255;
	localparam logic [FIELD_W-1:0] RJW_MAX      = 8'd4;
	localparam logic [FIELD_W-1:0] SEG_MAX      = 8'd8;

	// Register indexes, decoded from address bit 2.
	localparam logic REG_CLOCK = 1'b0;
	localparam logic REG_PROP  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICKS,
		S_CHECK,
		S_TRIAL,
		S_SEG,
		S_FAIL
	} state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] prop_len;
		logic [FIELD_W-1:0] phase1;
		logic [FIELD_W-1:0] phase2;
		logic [FIELD_W-1:0] rjw;
		logic               bad;
	} seg_t;

endpackage

// ===== hw/rtl/cbtc_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division producing one quotient bit per cycle; the dividend
// shifts out of the quotient register as the quotient bits shift in.
// ----------------------------------------------------------------------------
module cbtc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cbtc_pkg::DIV_W-1:0] dividend,
	input  logic [cbtc_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [cbtc_pkg::DIV_W-1:0] quotient,
	output logic [cbtc_pkg::DIV_W-1:0] remainder
);
	import cbtc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= LAST_STEP;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/cbtc_seg.sv =====
// ----------------------------------------------------------------------------
// Segment calculator
// Splits the quanta per bit into propagation, phase 1 and phase 2 segments
// around a sample point at seven eighths of the bit, in 8-bit wrap arithmetic.
// ----------------------------------------------------------------------------
module cbtc_seg (
	input  logic [cbtc_pkg::NBT_W-1:0]  nbt,
	input  logic [cbtc_pkg::PROP_W-1:0] prop,
	output cbtc_pkg::seg_t              seg
);
	import cbtc_pkg::*;

	logic [6:0]         nbt7;
	logic [6:0]         prod;
	logic [FIELD_W-1:0] prop8;
	logic [FIELD_W-1:0] p1;
	logic [FIELD_W-1:0] p2;

	assign nbt7  = {2'b0, nbt};
	// Seven times the quanta count, as eight times less one times.
	assign prod  = (nbt7 << 3) - nbt7;
	assign prop8 = {4'b0, prop};
	assign p1    = {4'b0, prod[6:3]} - 8'd1 - prop8;
	assign p2    = {3'b0, nbt} - 8'd1 - p1 - prop8;

	always_comb begin
		seg.prop_len = prop8;
		seg.phase1   = p1;
		seg.phase2   = p2;
		seg.rjw      = (p2 < RJW_MAX) ? p2 : RJW_MAX;
		seg.bad      = (p1 > SEG_MAX) || (p2 > SEG_MAX) || (prop8 > SEG_MAX);
	end

endmodule

// ===== hw/rtl/can_bit_timing_calculator_top.sv =====
// Sequence: a zero bit rate goes straight to the fail state; otherwise the tick count
// division runs first, then one division per prescaler trial, up to prescaler 255.
// Both are done by the shared bit-serial divider, one quotient bit per cycle.
// Throughput: one request at a time; busy stays high until the result beat.
// The result is shown for one cycle with done and cannot be stalled.
// Reset: asynchronous, active low; registers return to 80 MHz and 5 quanta.
// ----------------------------------------------------------------------------
// CAN bit-timing calculator
// Works out prescaler and segment lengths for a requested bit rate by
// searching prescalers with a serial divider; APB port for the clock and
// propagation segment registers.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cbtc_pkg::ADDR_W-1:0]   paddr,
	input  logic [cbtc_pkg::APB_W-1:0]    pwdata,
	output logic [cbtc_pkg::APB_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [cbtc_pkg::RATE_W-1:0]   bit_rate,
	output logic                          done,
	output logic [cbtc_pkg::FIELD_W-1:0]  prescaler,
	output logic [cbtc_pkg::FIELD_W-1:0]  prop_seg_out,
	output logic [cbtc_pkg::FIELD_W-1:0]  phase1_len,
	output logic [cbtc_pkg::FIELD_W-1:0]  phase2_len,
	output logic [cbtc_pkg::FIELD_W-1:0]  resync_width,
	output logic                          status
);
	import cbtc_pkg::*;

	state_t state_q, state_d;

	logic [CLK_W-1:0]   clock_q;
	logic [PROP_W-1:0]  prop_q;
	logic [DIV_W-1:0]   ticks_q;
	logic [FIELD_W-1:0] pre_q;
	logic [NBT_W-1:0]   nbt_q;
	logic               done_q;
	logic [FIELD_W-1:0] prescaler_q;
	logic [FIELD_W-1:0] prop_out_q;
	logic [FIELD_W-1:0] phase1_q;
	logic [FIELD_W-1:0] phase2_q;
	logic [FIELD_W-1:0] rjw_q;
	logic               status_q;

	logic               accept;
	logic               cfg_wr;
	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIV_W-1:0]   div_rem;
	logic               hit;
	seg_t               seg;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
			prop_q  <= PROP_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CLOCK: clock_q <= pwdata[CLK_W-1:0];
				REG_PROP:  prop_q  <= pwdata[PROP_W-1:0];
				default:   clock_q <= clock_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CLOCK: prdata = {{(APB_W-CLK_W){1'b0}}, clock_q};
			REG_PROP:  prdata = {{(APB_W-PROP_W){1'b0}}, prop_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------- datapath units ----------------
	cbtc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	cbtc_seg u_seg (
		.nbt  (nbt_q),
		.prop (prop_q),
		.seg  (seg)
	);

	assign accept = start && !busy;
	// A trial succeeds when the prescaler divides the ticks exactly into few enough quanta.
	assign hit    = (div_rem == '0) && (div_quo < QUANTA_LIMIT);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (bit_rate == '0) ? S_FAIL : S_TICKS;
				end
			end
			S_TICKS: begin
				if (div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = ({{(DIV_W-FIELD_W){1'b0}}, pre_q} > ticks_q) ? S_FAIL : S_TRIAL;
			end
			S_TRIAL: begin
				if (div_done) begin
					if (hit) begin
						state_d = S_SEG;
					end else if (pre_q == PRE_LAST) begin
						state_d = S_FAIL;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_SEG:   state_d = S_IDLE;
			S_FAIL:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy         = (state_q != S_IDLE);
		div_start    = 1'b0;
		div_dividend = ticks_q;
		div_divisor  = {{(DIV_W-FIELD_W){1'b0}}, pre_q};
		case (state_q)
			S_IDLE: begin
				div_dividend = clock_q;
				div_divisor  = bit_rate;
				div_start    = accept && (bit_rate != '0);
			end
			S_CHECK: begin
				div_start = ({{(DIV_W-FIELD_W){1'b0}}, pre_q} <= ticks_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			pre_q   <= PRE_FIRST;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_SEG) || (state_q == S_FAIL);
			if (state_q == S_TICKS && div_done) begin
				pre_q <= PRE_FIRST;
			end else if (state_q == S_TRIAL && div_done && !hit && pre_q != PRE_LAST) begin
				pre_q <= pre_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TICKS && div_done) begin
			ticks_q <= div_quo;
		end
		if (state_q == S_TRIAL && div_done) begin
			nbt_q <= div_quo[NBT_W-1:0];
		end
		case (state_q)
			S_SEG: begin
				prescaler_q <= pre_q;
				prop_out_q  <= seg.prop_len;
				phase1_q    <= seg.phase1;
				phase2_q    <= seg.phase2;
				rjw_q       <= seg.rjw;
				status_q    <= seg.bad;
			end
			S_FAIL: begin
				prescaler_q <= '0;
				prop_out_q  <= '0;
				phase1_q    <= '0;
				phase2_q    <= '0;
				rjw_q       <= '0;
				status_q    <= 1'b1;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign done         = done_q;
	assign prescaler    = prescaler_q;
	assign prop_seg_out = prop_out_q;
	assign phase1_len   = phase1_q;
	assign phase2_len   = phase2_q;
	assign resync_width = rjw_q;
	assign status       = status_q;

	// ---------------- assertions ----------------
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_TICKS || state_q == S_TRIAL))
		else $error("divider finished while the sequencer was not waiting");

	a_valid_has_prescaler: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !status) |-> (prescaler != '0))
		else $error("valid timing reported with a zero prescaler");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not make the block busy");

endmodule
